/* hw/rtl/gnd_pkg.sv */
`timescale 1ns / 1ps

package gnd_pkg;

   localparam int AmountW  = 24;
   localparam int FaceW    = 16;
   localparam int CountW   = 16;
   localparam int SlotW    = 3;
   localparam int NotesW   = 19;
   localparam int ValueW   = 35;
   localparam int ProdW    = 32;
   localparam int DivCntW  = 5;
   localparam int ReqDataW = 64;
   localparam int RspDataW = 80;

   localparam logic REQ_LOAD     = 1'b0;
   localparam logic REQ_WITHDRAW = 1'b1;

   typedef struct packed {
      logic load;
      logic start;
      logic idx_clr;
      logic idx_inc;
      logic zero_take;
      logic div_start;
      logic take_set;
      logic mul_take;
      logic sub_amt;
      logic set_refuse;
      logic commit;
      logic mul_tot;
      logic acc_tot;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic refuse;
      logic face_zero;
      logic idx_last;
      logic div_done;
      logic amount_zero;
      logic rsp_free;
   } status_type;

endpackage

/* hw/rtl/gnd_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module gnd_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [gnd_pkg::AmountW-1:0]       dividend,
   input  logic [gnd_pkg::FaceW-1:0]         divisor,
   output logic                              done,
   output logic [gnd_pkg::AmountW-1:0]       quotient
);

   logic [gnd_pkg::AmountW-1:0] quo_ff, quo_in;
   logic [gnd_pkg::FaceW-1:0]   rem_ff, rem_in;
   logic [gnd_pkg::FaceW-1:0]   dvs_ff, dvs_in;
   logic [gnd_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [gnd_pkg::FaceW:0]     trial;
   logic [gnd_pkg::FaceW:0]     diff;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[gnd_pkg::AmountW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[gnd_pkg::FaceW-1:0] : trial[gnd_pkg::FaceW-1:0];
         quo_in = {quo_ff[gnd_pkg::AmountW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == gnd_pkg::DivCntW'(gnd_pkg::AmountW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hw/rtl/gnd_dp.sv */
`timescale 1ns / 1ps

module gnd_dp #(
   parameter int NUM_DENOMS = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gnd_pkg::cmd_type                  cmd,
   output gnd_pkg::status_type               st,
   input  logic [gnd_pkg::ReqDataW-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gnd_pkg::RspDataW-1:0]      rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int IdxW = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;

   logic [gnd_pkg::SlotW-1:0]   req_slot;
   logic [gnd_pkg::FaceW-1:0]   req_face;
   logic [gnd_pkg::CountW-1:0]  req_count;
   logic [gnd_pkg::AmountW-1:0] req_amount;

   assign req_slot   = req_tdata[2:0];
   assign req_face   = req_tdata[18:3];
   assign req_count  = req_tdata[34:19];
   assign req_amount = req_tdata[58:35];

   logic [gnd_pkg::FaceW-1:0]   face_ff  [NUM_DENOMS];
   logic [gnd_pkg::FaceW-1:0]   face_in  [NUM_DENOMS];
   logic [gnd_pkg::CountW-1:0]  stock_ff [NUM_DENOMS];
   logic [gnd_pkg::CountW-1:0]  stock_in [NUM_DENOMS];
   logic [gnd_pkg::CountW-1:0]  plan_ff  [NUM_DENOMS];
   logic [gnd_pkg::CountW-1:0]  plan_in  [NUM_DENOMS];

   logic [IdxW-1:0]             idx_ff, idx_in;
   logic [gnd_pkg::AmountW-1:0] amount_ff, amount_in;
   logic                        refuse_ff, refuse_in;
   logic [gnd_pkg::CountW-1:0]  take_ff, take_in;
   logic [gnd_pkg::ProdW-1:0]   prod_ff, prod_in;
   logic [gnd_pkg::NotesW-1:0]  notes_ff, notes_in;
   logic [gnd_pkg::ValueW-1:0]  value_ff, value_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gnd_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic                        rsp_refused_ff, rsp_refused_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [IdxW+2:0]             slot_ext;
   logic [IdxW-1:0]             slot_idx;
   logic                        slot_ok;
   logic [IdxW+2:0]             idx_ext;
   logic                        idx_last;
   logic [gnd_pkg::FaceW-1:0]   cur_face;
   logic [gnd_pkg::CountW-1:0]  cur_stock;
   logic [gnd_pkg::CountW-1:0]  mul_a;
   logic                        div_done;
   logic [gnd_pkg::AmountW-1:0] quotient;
   logic                        rsp_free;
   logic                        emit_last;
   logic [gnd_pkg::SlotW-1:0]   emit_slot;
   logic [gnd_pkg::CountW-1:0]  emit_given;
   logic [gnd_pkg::NotesW-1:0]  emit_notes;
   logic [gnd_pkg::ValueW-1:0]  emit_value;

   assign slot_ext  = {{IdxW{1'b0}}, req_slot};
   assign slot_idx  = slot_ext[IdxW-1:0];
   assign slot_ok   = (32'(req_slot) < 32'(NUM_DENOMS));
   assign idx_ext   = {3'b000, idx_ff};
   assign idx_last  = (idx_ff == IdxW'(NUM_DENOMS - 1));
   assign cur_face  = face_ff[idx_ff];
   assign cur_stock = stock_ff[idx_ff];
   assign mul_a     = cmd.mul_take ? take_ff : cur_stock;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   gnd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (amount_ff),
      .divisor  (cur_face),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      face_in  = face_ff;
      stock_in = stock_ff;
      plan_in  = plan_ff;
      if (cmd.load && slot_ok) begin
         face_in[slot_idx]  = req_face;
         stock_in[slot_idx] = req_count;
      end
      if (cmd.commit)
         stock_in[idx_ff] = cur_stock - plan_ff[idx_ff];
      if (cmd.zero_take)
         plan_in[idx_ff] = '0;
      if (cmd.sub_amt)
         plan_in[idx_ff] = take_ff;
   end

   always_comb begin
      idx_in    = idx_ff;
      amount_in = amount_ff;
      refuse_in = refuse_ff;
      take_in   = take_ff;
      prod_in   = prod_ff;
      notes_in  = notes_ff;
      value_in  = value_ff;
      if (cmd.idx_clr)
         idx_in = '0;
      else if (cmd.idx_inc)
         idx_in = idx_ff + 1'b1;
      if (cmd.start) begin
         amount_in = req_amount;
         refuse_in = (req_amount == '0);
         notes_in  = '0;
         value_in  = '0;
      end
      if (cmd.set_refuse)
         refuse_in = 1'b1;
      if (cmd.take_set)
         take_in = (quotient > {8'h00, cur_stock}) ? cur_stock
                                                   : quotient[gnd_pkg::CountW-1:0];
      if (cmd.mul_take || cmd.mul_tot)
         prod_in = {16'h0000, mul_a} * {16'h0000, cur_face};
      if (cmd.sub_amt)
         amount_in = amount_ff - prod_ff[gnd_pkg::AmountW-1:0];
      if (cmd.acc_tot) begin
         notes_in = notes_ff + {3'b000, cur_stock};
         value_in = value_ff + {3'b000, prod_ff};
      end
   end

   // result register
   assign emit_last  = refuse_ff || idx_last;
   assign emit_slot  = refuse_ff ? '0 : idx_ext[2:0];
   assign emit_given = refuse_ff ? '0 : plan_ff[idx_ff];
   assign emit_notes = emit_last ? notes_ff : '0;
   assign emit_value = emit_last ? value_ff : '0;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_refused_in = rsp_refused_ff;
      rsp_last_in    = rsp_last_ff;
      if (rsp_tready)
         rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_data_in    = {7'b0000000, emit_value, emit_notes, emit_given, emit_slot};
         rsp_refused_in = refuse_ff;
         rsp_last_in    = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DENOMS; i++) begin
            face_ff[i]  <= '0;
            stock_ff[i] <= '0;
         end
         idx_ff       <= '0;
         amount_ff    <= '0;
         refuse_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         face_ff      <= face_in;
         stock_ff     <= stock_in;
         idx_ff       <= idx_in;
         amount_ff    <= amount_in;
         refuse_ff    <= refuse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      plan_ff        <= plan_in;
      take_ff        <= take_in;
      prod_ff        <= prod_in;
      notes_ff       <= notes_in;
      value_ff       <= value_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_refused_ff <= rsp_refused_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign st.refuse      = refuse_ff;
   assign st.face_zero   = (cur_face == '0);
   assign st.idx_last    = idx_last;
   assign st.div_done    = div_done;
   assign st.amount_zero = (amount_ff == '0);
   assign st.rsp_free    = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_refused_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hw/rtl/gnd_ctrl.sv */
`timescale 1ns / 1ps

module gnd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,
   input  gnd_pkg::status_type st,
   output gnd_pkg::cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_WALK   = 10'b00_0000_0010,
      S_DIV    = 10'b00_0000_0100,
      S_MUL    = 10'b00_0000_1000,
      S_SUB    = 10'b00_0001_0000,
      S_CHECK  = 10'b00_0010_0000,
      S_COMMIT = 10'b00_0100_0000,
      S_TMUL   = 10'b00_1000_0000,
      S_TACC   = 10'b01_0000_0000,
      S_EMIT   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      req_acc;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tuser == gnd_pkg::REQ_WITHDRAW) begin
                  cmd.start   = 1'b1;
                  cmd.idx_clr = 1'b1;
                  state_in    = S_WALK;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_WALK: begin
            if (st.refuse) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_TMUL;
            end else if (st.face_zero) begin
               cmd.zero_take = 1'b1;
               if (st.idx_last) begin
                  state_in = S_CHECK;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (st.div_done) begin
               cmd.take_set = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_take = 1'b1;
            state_in     = S_SUB;
         end
         S_SUB: begin
            cmd.sub_amt = 1'b1;
            if (st.idx_last) begin
               state_in = S_CHECK;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_WALK;
            end
         end
         S_CHECK: begin
            cmd.idx_clr = 1'b1;
            if (st.amount_zero) begin
               state_in = S_COMMIT;
            end else begin
               cmd.set_refuse = 1'b1;
               state_in       = S_TMUL;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            if (st.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_TMUL;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_TMUL: begin
            cmd.mul_tot = 1'b1;
            state_in    = S_TACC;
         end
         S_TACC: begin
            cmd.acc_tot = 1'b1;
            if (st.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_TMUL;
            end
         end
         S_EMIT: begin
            if (st.rsp_free) begin
               cmd.emit = 1'b1;
               if (st.refuse || st.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/greedy_note_dispenser_top.sv */
`timescale 1ns / 1ps
// Load item: stored in its slot when slot < NUM_DENOMS, no result.
// Withdraw item: per slot nothing when unused, else serial divide, multiply and subtract;
// then commit (unless refused), totals per slot and one result per slot, or a single refusal.
// Next item is taken once the last result sits in the output register.
// Synchronous reset empties every slot and drops any pending result.
module greedy_note_dispenser_top #(
   parameter int NUM_DENOMS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // slot[2:0], face_value[18:3], note_count[34:19], amount[58:35]
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // out_slot[2:0], notes_given[18:3], remaining_notes[37:19],
                                   // remaining_value[72:38]
   output logic        rsp_tuser,  // refused
   output logic        rsp_tlast   // last
);

   gnd_pkg::cmd_type    cmd;
   gnd_pkg::status_type st;

   gnd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .st         (st),
      .cmd        (cmd)
   );

   gnd_dp #(
      .NUM_DENOMS (NUM_DENOMS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* hw/rtl/gnd_chk.sv */
`timescale 1ns / 1ps

module gnd_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_refuse_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("refusal not marked last");

   a_refuse_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[18:0] == 19'd0)
      else $error("refusal carries slot or notes");

   a_totals_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[72:19] == 54'd0)
      else $error("totals on a non-final item");

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid && !rsp_tready |=> !rsp_tvalid || rsp_tlast)
      else $error("input taken mid-request");

endmodule

bind greedy_note_dispenser_top gnd_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
